### design/tlbsc_pkg.sv
// Shared types, codes and defaults for the second-chance TLB.
package tlbsc_pkg;

  // Default geometry
  localparam int DEF_ENTRIES    = 16;
  localparam int DEF_PAGE_BITS  = 20;
  localparam int DEF_FRAME_BITS = 16;

  // Operation codes carried in the mode field
  localparam logic [1:0] MODE_LOOKUP = 2'd0;
  localparam logic [1:0] MODE_ADD    = 2'd1;
  localparam logic [1:0] MODE_UNSET  = 2'd2;

  // Input transaction
  typedef struct packed {
    logic [1:0]  mode;
    logic [19:0] page;
    logic [15:0] frame;
    logic        write_access;
    logic        ref_in;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    logic        hit;
    logic [15:0] frame_out;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic [31:0] change_total;
  } out_item_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;     // capture the accepted transaction
    logic exec;        // execute lookup, unset, update or fill
    logic sweep_step;  // clear reference bit under the hand and advance
    logic victim;      // replace the entry under the hand
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_sweep;  // add found neither its page nor a free slot
    logic victim_ok;   // reference bit under the hand is clear
  } sts_t;

endpackage

### design/tlbsc_ctrl.sv
// Controller state machine and result handshake for the second-chance TLB.
module tlbsc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  tlbsc_pkg::sts_t sts,
  output tlbsc_pkg::cmd_t cmd
);
  import tlbsc_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   load_result;

  // State and result-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input is taken in idle once the result register is free or being drained
  assign in_ready  = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    load_result = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts.need_sweep) begin
          state_nxt = ST_SWEEP;
        end else begin
          cmd.exec    = 1'b1;
          load_result = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      ST_SWEEP: begin
        if (sts.victim_ok) begin
          cmd.victim  = 1'b1;
          load_result = 1'b1;
          state_nxt   = ST_IDLE;
        end else begin
          cmd.sweep_step = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Result register is full after a finish, empty once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (load_result) out_valid_nxt = 1'b1;
  end

endmodule

### design/tlbsc_dp.sv
// Entry store, parallel match, clock hand, counters and result register.
module tlbsc_dp #(
  parameter int ENTRIES    = tlbsc_pkg::DEF_ENTRIES,
  parameter int PAGE_BITS  = tlbsc_pkg::DEF_PAGE_BITS,
  parameter int FRAME_BITS = tlbsc_pkg::DEF_FRAME_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tlbsc_pkg::in_item_t  in_data,
  input  tlbsc_pkg::cmd_t      cmd,
  output tlbsc_pkg::sts_t      sts,
  output tlbsc_pkg::out_item_t out_data
);
  import tlbsc_pkg::*;

  localparam int HW = $clog2(ENTRIES);
  localparam logic [HW-1:0] LAST = HW'(ENTRIES - 1);

  // Captured transaction
  in_item_t in_r;

  // Entry store
  logic [ENTRIES-1:0]    valid_r;
  logic [ENTRIES-1:0]    ref_r;
  logic [PAGE_BITS-1:0]  page_r  [ENTRIES];
  logic [FRAME_BITS-1:0] frame_r [ENTRIES];
  logic [HW-1:0]         hand_r;

  // Counters
  logic [31:0] hits_r, hits_nxt;
  logic [31:0] misses_r, misses_nxt;
  logic [31:0] changes_r, changes_nxt;

  out_item_t res_r;

  logic [PAGE_BITS-1:0]  pg;
  logic [FRAME_BITS-1:0] fr;
  logic [ENTRIES-1:0]    page_eq;
  logic [ENTRIES-1:0]    match;
  logic [ENTRIES-1:0]    fill_oh;
  logic [FRAME_BITS-1:0] hit_frame;
  logic                  any_match;
  logic                  any_free;
  logic                  seen_free;
  logic                  is_lookup;
  logic                  is_add;
  logic                  hit_now;
  logic [HW-1:0]         hand_inc;

  assign pg = PAGE_BITS'(in_r.page);
  assign fr = FRAME_BITS'(in_r.frame);

  // Parallel compare and first free slot
  always_comb begin
    hit_frame = '0;
    seen_free = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      page_eq[i] = (page_r[i] == pg);
      match[i]   = valid_r[i] && page_eq[i];
      fill_oh[i] = !valid_r[i] && !seen_free;
      seen_free  = seen_free || !valid_r[i];
      if (match[i]) hit_frame = hit_frame | frame_r[i];
    end
  end

  assign any_match = |match;
  assign any_free  = |(~valid_r);
  assign is_lookup = (in_r.mode == MODE_LOOKUP);
  assign is_add    = (in_r.mode == MODE_ADD);
  assign hit_now   = cmd.exec && is_lookup && any_match;
  assign hand_inc  = (hand_r == LAST) ? '0 : hand_r + 1'b1;

  assign sts.need_sweep = is_add && !any_match && !any_free;
  assign sts.victim_ok  = !ref_r[hand_r];

  // Counter updates
  always_comb begin
    hits_nxt    = hits_r + 32'(hit_now);
    misses_nxt  = misses_r + 32'(cmd.exec && is_lookup && !any_match);
    changes_nxt = changes_r + 32'((cmd.exec && is_add) || cmd.victim);
  end

  // Control state: valid bits, hand and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      hand_r    <= '0;
      hits_r    <= '0;
      misses_r  <= '0;
      changes_r <= '0;
    end else begin
      hits_r    <= hits_nxt;
      misses_r  <= misses_nxt;
      changes_r <= changes_nxt;
      if (cmd.exec) begin
        case (in_r.mode)
          MODE_ADD: if (!any_match) valid_r <= valid_r | fill_oh;
          MODE_UNSET: valid_r <= valid_r & ~page_eq;
          default: ;
        endcase
      end
      if (cmd.sweep_step) hand_r <= hand_inc;
    end
  end

  // Payload: captured input, entry contents, reference bits, result
  always_ff @(posedge clk) begin
    if (cmd.load_in) in_r <= in_data;
    if (cmd.exec) begin
      case (in_r.mode)
        MODE_LOOKUP: begin
          for (int i = 0; i < ENTRIES; i++)
            if (match[i]) ref_r[i] <= in_r.write_access;
        end
        MODE_ADD: begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (any_match ? match[i] : fill_oh[i]) begin
              page_r[i]  <= pg;
              frame_r[i] <= fr;
              ref_r[i]   <= in_r.ref_in;
            end
          end
        end
        default: ;
      endcase
    end
    if (cmd.sweep_step) ref_r[hand_r] <= 1'b0;
    if (cmd.victim) begin
      page_r[hand_r]  <= pg;
      frame_r[hand_r] <= fr;
      ref_r[hand_r]   <= in_r.ref_in;
    end
    if (cmd.exec || cmd.victim) begin
      res_r.hit          <= hit_now;
      res_r.frame_out    <= hit_now ? 16'(hit_frame) : 16'd0;
      res_r.hit_total    <= hits_nxt;
      res_r.miss_total   <= misses_nxt;
      res_r.change_total <= changes_nxt;
    end
  end

  assign out_data = res_r;

endmodule

### design/tlb_second_chance.sv
// Top level of the fully associative TLB with second-chance replacement.
// Each transaction is a lookup, an add or an unset. A lookup, an unset and an add that
// updates its page or fills a free slot raise out_valid after the execute state, and
// the next transaction can be accepted at the edge where that result is taken; only one
// transaction is in flight at a time. An add that finds the table full walks the clock
// hand one entry per cycle, clearing set reference bits, until it finds a clear one and
// replaces that entry. The result register holds one finished result while it waits;
// counters wrap at 32 bits.
module tlb_second_chance #(
  parameter int ENTRIES    = tlbsc_pkg::DEF_ENTRIES,
  parameter int PAGE_BITS  = tlbsc_pkg::DEF_PAGE_BITS,
  parameter int FRAME_BITS = tlbsc_pkg::DEF_FRAME_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tlbsc_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tlbsc_pkg::out_item_t out_data
);
  import tlbsc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  tlbsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Entry store and arithmetic
  tlbsc_dp #(
    .ENTRIES    (ENTRIES),
    .PAGE_BITS  (PAGE_BITS),
    .FRAME_BITS (FRAME_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

  // One transaction in flight: no second acceptance straight after the first
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a transaction is in flight");

  // Result register is empty while a transaction is being worked on
  a_out_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !out_valid)
    else $error("result still pending after acceptance");

  // A new result only appears after work done with input closed
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without work cycle");

  // A miss or non-lookup reports frame zero
  a_miss_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.hit) |-> (out_data.frame_out == 16'd0))
    else $error("frame reported without a hit");

endmodule

### bench/tlb_checker.sv
// Transaction monitor and TLB predictor that checks every result of the second-chance TLB.
module tlb_checker #(
  parameter int ENTRIES = tlbsc_pkg::DEF_ENTRIES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  tlbsc_pkg::in_item_t  in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  tlbsc_pkg::out_item_t out_data,
  output int                   fail_count,
  output int                   pending
);
  import tlbsc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Predicted translation table
  logic        tvalid [ENTRIES];
  logic [19:0] tpage  [ENTRIES];
  logic [15:0] tframe [ENTRIES];
  logic        tref   [ENTRIES];
  int          hand;
  logic [31:0] hit_cnt, miss_cnt, add_cnt;

  out_item_t awaited_results [$];
  out_item_t want;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // Lowest valid slot holding the page, or -1
  function automatic int find_page(input logic [19:0] pg);
    for (int i = 0; i < ENTRIES; i++) begin
      if (tvalid[i] && tpage[i] == pg) return i;
    end
    return -1;
  endfunction

  // Apply one transaction to the predicted table and return its result
  function automatic out_item_t tlb_apply(input in_item_t op);
    out_item_t r;
    int        slot;
    int        h;
    r = '0;
    case (op.mode)
      MODE_LOOKUP: begin
        slot = find_page(op.page);
        if (slot >= 0) begin
          tref[slot]  = op.write_access;
          r.hit       = 1'b1;
          r.frame_out = tframe[slot];
          hit_cnt     = hit_cnt + 1;
        end else begin
          miss_cnt = miss_cnt + 1;
        end
      end
      MODE_ADD: begin
        add_cnt = add_cnt + 1;
        slot = find_page(op.page);
        // no match: lowest free slot
        if (slot < 0) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (!tvalid[i]) begin
              slot = i;
              break;
            end
          end
        end
        // table full: clock sweep, hand parks on the victim
        if (slot < 0) begin
          h = hand;
          while (tref[h]) begin
            tref[h] = 1'b0;
            h = (h + 1) % ENTRIES;
          end
          hand = h;
          slot = h;
        end
        tvalid[slot] = 1'b1;
        tpage[slot]  = op.page;
        tframe[slot] = op.frame;
        tref[slot]   = op.ref_in;
      end
      MODE_UNSET: begin
        // matches stored pages whether valid or not
        for (int i = 0; i < ENTRIES; i++) begin
          if (tpage[i] == op.page) tvalid[i] = 1'b0;
        end
      end
      default: ;
    endcase
    r.hit_total    = hit_cnt;
    r.miss_total   = miss_cnt;
    r.change_total = add_cnt;
    return r;
  endfunction

  task automatic check_field(input string field, input logic [31:0] exp_v, got_v);
    if (got_v !== exp_v) begin
      $display("%0t ns: %s expected %h, got %h", $time, field, exp_v, got_v);
      fail_count++;
    end
  endtask

  // Sample both channels at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        tvalid[i] = 1'b0;
        tpage[i]  = '0;
        tframe[i] = '0;
        tref[i]   = 1'b0;
      end
      hand     = 0;
      hit_cnt  = '0;
      miss_cnt = '0;
      add_cnt  = '0;
      awaited_results.delete();
    end else begin
      if (in_valid && in_ready) awaited_results.push_back(tlb_apply(in_data));
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t ns: unexpected result transaction %h", $time, out_data);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("hit", 32'(want.hit), 32'(out_data.hit));
          check_field("frame_out", 32'(want.frame_out), 32'(out_data.frame_out));
          check_field("hit_total", want.hit_total, out_data.hit_total);
          check_field("miss_total", want.miss_total, out_data.miss_total);
          check_field("change_total", want.change_total, out_data.change_total);
        end
      end
    end
    pending = awaited_results.size();
  end

endmodule

### bench/testbench.sv
// Top of the TLB testbench: clock, reset, transaction stimulus, result back-pressure, verdict.
module testbench;
  import tlbsc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int         N_RANDOM   = 950;
  localparam int         POOL_SIZE  = 24;
  localparam int         LIMIT      = 500000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  int        fail_count;
  int        pending;
  int        cycle_count = 0;
  bit        calm = 1'b0;

  logic [19:0] page_pool [POOL_SIZE];

  tlb_second_chance uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  tlb_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Mostly no gap, some short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic in_item_t make_op(input logic [1:0] mode, input logic [19:0] pg,
                                       input logic [15:0] fr, input logic wr, input logic rb);
    in_item_t op;
    op.mode         = mode;
    op.page         = pg;
    op.frame        = fr;
    op.write_access = wr;
    op.ref_in       = rb;
    return op;
  endfunction

  // Random transaction, pages mostly from a pool a little larger than the table
  function automatic in_item_t random_op();
    int         r;
    logic [1:0] mode;
    logic [19:0] pg;
    r = $urandom_range(0, 99);
    if (r < 45)      mode = MODE_LOOKUP;
    else if (r < 80) mode = MODE_ADD;
    else if (r < 97) mode = MODE_UNSET;
    else             mode = MODE_SPARE;
    if ($urandom_range(0, 9) == 0) pg = 20'($urandom());
    else pg = page_pool[$urandom_range(0, POOL_SIZE - 1)];
    return make_op(mode, pg, 16'($urandom()), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
  endfunction

  // Present one transaction from a falling edge and hold it until taken
  task automatic issue(input in_item_t op);
    in_data  <= op;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic pause(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // Result back-pressure
  initial begin
    int hold;
    hold = 0;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold == 0 && !calm && $urandom_range(0, 3) == 0) hold = gap_len();
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Stimulus and verdict
  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty table, extremes, update, no-match unset, full sweep
    issue(make_op(MODE_LOOKUP, 20'h00000, 16'h0000, 1'b1, 1'b0));
    issue(make_op(MODE_UNSET,  20'h00000, 16'h0000, 1'b0, 1'b0));
    issue(make_op(MODE_SPARE,  20'hFFFFF, 16'hFFFF, 1'b1, 1'b1));
    issue(make_op(MODE_ADD,    20'h00000, 16'hFFFF, 1'b0, 1'b1));
    issue(make_op(MODE_ADD,    20'hFFFFF, 16'h0000, 1'b1, 1'b0));
    issue(make_op(MODE_LOOKUP, 20'h00000, 16'h0000, 1'b0, 1'b0));
    issue(make_op(MODE_LOOKUP, 20'hFFFFF, 16'hFFFF, 1'b1, 1'b1));
    issue(make_op(MODE_ADD,    20'h00000, 16'h5A5A, 1'b0, 1'b1));
    issue(make_op(MODE_UNSET,  20'h12345, 16'h0000, 1'b0, 1'b0));
    // fill the rest with set reference bits so the sweep goes all the way round
    for (int i = 2; i < DEF_ENTRIES; i++) begin
      issue(make_op(MODE_ADD, 20'h00100 + 20'(i), 16'(i * 'h111), 1'b0, 1'b1));
    end
    issue(make_op(MODE_ADD,    20'hABCDE, 16'hA5A5, 1'b0, 1'b0));
    issue(make_op(MODE_LOOKUP, 20'hABCDE, 16'h0000, 1'b0, 1'b0));
    issue(make_op(MODE_UNSET,  20'hFFFFF, 16'h0000, 1'b0, 1'b0));

    // Random: pool refreshed now and then, one stretch with no idling
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 200 == 0) begin
        for (int k = 0; k < POOL_SIZE; k++) page_pool[k] = 20'($urandom());
      end
      calm = (n >= 400 && n < 500);
      issue(random_op());
      pause(calm ? 0 : gap_len());
    end
    in_valid <= 1'b0;
    calm = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (fail_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
